// ===== src/civ_fd_pkg.sv =====
// shared constants, types and band tables for the frame frequency decoder
// no dependencies; used by every module of the block
`default_nettype none

package civ_fd_pkg;

  localparam logic [7:0] EndByte     = 8'hFD;
  localparam logic [3:0] LastPos     = 4'd10;
  localparam logic [3:0] FirstData   = 4'd5;
  localparam int unsigned NumData    = 5;
  localparam int unsigned NumBands   = 11;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned FreqW = 31;
  localparam int unsigned BandW = 4;
  localparam int unsigned AntW  = 2;

  // digit weights of the data bytes, 10 Hz units
  localparam logic [FreqW-1:0] Weight1 = 31'd10;
  localparam logic [FreqW-1:0] Weight2 = 31'd1000;
  localparam logic [FreqW-1:0] Weight3 = 31'd100000;
  localparam logic [FreqW-1:0] Weight4 = 31'd10000000;
  // x/10 as (x*205)>>11, exact for x below 1029
  localparam logic [15:0] RecipTen   = 16'd205;
  localparam int unsigned RecipShift = 11;

  localparam logic [AntW-1:0] AntNone = 2'd0;
  localparam logic [AntW-1:0] AntHigh = 2'd1;
  localparam logic [AntW-1:0] AntLow  = 2'd2;

  localparam logic [FreqW-1:0] BandLo [NumBands] = '{
    31'd181000, 31'd350000, 31'd535100, 31'd700000, 31'd1010000, 31'd1400000,
    31'd1806800, 31'd2100000, 31'd2489000, 31'd2800000, 31'd5000000
  };
  localparam logic [FreqW-1:0] BandHi [NumBands] = '{
    31'd200000, 31'd380000, 31'd536600, 31'd720000, 31'd1015000, 31'd1435000,
    31'd1816800, 31'd2145000, 31'd2499000, 31'd2970000, 31'd5200000
  };
  localparam logic [BandW-1:0] FirstHighBand = 4'd6;

  // data bytes of one complete frame, positions 5..9
  typedef logic [7:0] frame_data_t [NumData];

  // bands are disjoint, so at most one range matches
  function automatic logic [BandW-1:0] classify_band(input logic [FreqW-1:0] f);
    logic [BandW-1:0] band;
    band = '0;
    for (int i = 0; i < NumBands; i++) begin
      if (f >= BandLo[i] && f <= BandHi[i]) begin
        band = BandW'(i + 1);
      end
    end
    return band;
  endfunction

  function automatic logic [AntW-1:0] pick_antenna(input logic [BandW-1:0] band);
    logic [AntW-1:0] ant;
    if (band == '0) begin
      ant = AntNone;
    end else if (band < FirstHighBand) begin
      ant = AntLow;
    end else if (band <= BandW'(NumBands)) begin
      ant = AntHigh;
    end else begin
      ant = AntNone;
    end
    return ant;
  endfunction

endpackage

`default_nettype wire

// ===== src/civ_frequency_frame_decoder_core.sv =====
// top level of the radio control frame frequency decoder
// instantiates civ_fd_front, civ_fd_queue and civ_fd_back; uses civ_fd_pkg
`default_nettype none

// Takes one received byte per cycle on the rx channel and gives one result
// (frequency in 10 Hz units, band 1..11 or 0, antenna 0..2) for each frame
// whose eleventh byte is the end byte 0xFD. Bytes are accepted back to back
// while the frame queue has room; once its end byte is taken, a frame passes
// through the queue and the decode pipeline (weigh digits, sum, classify)
// to the result. The queue of QueueDepth frames lets bytes keep flowing while
// results wait at the output register.
module civ_frequency_frame_decoder_core #(
  parameter int unsigned QueueDepth = civ_fd_pkg::QueueDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [7:0]                 rx_byte_i,
  input  wire logic                       rx_valid_i,
  output logic                            rx_ready_o,
  output logic [civ_fd_pkg::FreqW-1:0]    frequency_o,
  output logic [civ_fd_pkg::BandW-1:0]    band_o,
  output logic [civ_fd_pkg::AntW-1:0]     antenna_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i
);

  logic                    push, space, q_valid, pop;
  civ_fd_pkg::frame_data_t push_frame, pop_frame;

  civ_fd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .push_o     (push),
    .frame_o    (push_frame),
    .space_i    (space)
  );

  civ_fd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .space_o (space),
    .valid_o (q_valid),
    .pop_i   (pop),
    .frame_o (pop_frame)
  );

  civ_fd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .pop_o       (pop),
    .frame_i     (pop_frame),
    .frequency_o (frequency_o),
    .band_o      (band_o),
    .antenna_o   (antenna_o),
    .valid_o     (res_valid_o),
    .ready_i     (res_ready_i)
  );

  // a frame is pushed only when the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> space)
    else $error("frame pushed into a full queue");

  // the decoder never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> q_valid)
    else $error("pop from an empty queue");

  // antenna is none exactly when the band is none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((band_o == '0) == (antenna_o == civ_fd_pkg::AntNone)))
    else $error("antenna does not match band");

  // an in-band result lies within the outer band limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && band_o != '0) |->
      (frequency_o >= civ_fd_pkg::BandLo[0] &&
       frequency_o <= civ_fd_pkg::BandHi[civ_fd_pkg::NumBands-1]))
    else $error("band given for a frequency outside all bands");

endmodule

`default_nettype wire

// ===== src/civ_fd_front.sv =====
// front end: tracks the frame write position, keeps data bytes 5..9 and
// hands a complete frame to the queue; uses civ_fd_pkg
`default_nettype none

module civ_fd_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [7:0]             rx_byte_i,
  input  wire logic                   rx_valid_i,
  output logic                        rx_ready_o,
  output logic                        push_o,
  output civ_fd_pkg::frame_data_t     frame_o,
  input  wire logic                   space_i
);

  logic [3:0] pos_q, pos_d;
  logic [7:0] data_q [civ_fd_pkg::NumData];
  logic       accept;
  logic       last;
  logic       is_end;
  logic       in_data;
  logic [2:0] data_off;

  assign rx_ready_o = space_i;
  assign accept     = rx_valid_i && space_i;
  assign last       = pos_q >= civ_fd_pkg::LastPos;
  assign is_end     = rx_byte_i == civ_fd_pkg::EndByte;
  assign in_data    = pos_q >= civ_fd_pkg::FirstData && !last;
  assign data_off   = 3'(pos_q - civ_fd_pkg::FirstData);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (is_end || last) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data) begin
      data_q[data_off] <= rx_byte_i;
    end
  end

  // frame is complete only when the eleventh byte is the end byte
  assign push_o  = accept && last && is_end;
  assign frame_o = data_q;

endmodule

`default_nettype wire

// ===== src/civ_fd_queue.sv =====
// short queue of complete frames between the front end and the decoder
// uses civ_fd_pkg for the frame type
`default_nettype none

module civ_fd_queue #(
  parameter int unsigned Depth = civ_fd_pkg::QueueDepth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  civ_fd_pkg::frame_data_t     frame_i,
  output logic                        space_o,
  output logic                        valid_o,
  input  wire logic                   pop_i,
  output civ_fd_pkg::frame_data_t     frame_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  civ_fd_pkg::frame_data_t mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign space_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && valid_o;
  assign frame_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= frame_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/civ_fd_back.sv =====
// decoder: weighs the digit pairs, sums them and classifies band and antenna
// in an elastic three stage pipeline; uses civ_fd_pkg
`default_nettype none

module civ_fd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            pop_o,
  input  civ_fd_pkg::frame_data_t         frame_i,
  output logic [civ_fd_pkg::FreqW-1:0]    frequency_o,
  output logic [civ_fd_pkg::BandW-1:0]    band_o,
  output logic [civ_fd_pkg::AntW-1:0]     antenna_o,
  output logic                            valid_o,
  input  wire logic                       ready_i
);

  localparam int unsigned W = civ_fd_pkg::FreqW;

  logic       v1_q, v2_q, v3_q;
  logic       ld1, ld2, ld3;
  logic       free1, free2;

  logic [7:0]   pair [civ_fd_pkg::NumData];
  logic [15:0]  tenth_prod;
  logic [W-1:0] term_d [civ_fd_pkg::NumData];
  logic [W-1:0] term_q [civ_fd_pkg::NumData];
  logic [W-1:0] sum_q;
  logic [W-1:0] freq_q;
  logic [civ_fd_pkg::BandW-1:0] band_q;
  logic [civ_fd_pkg::AntW-1:0]  ant_q;
  logic [civ_fd_pkg::BandW-1:0] band_d;

  // stall control, a stage loads when the one after it has room
  assign ld3   = v2_q && (!v3_q || ready_i);
  assign free2 = !v2_q || ld3;
  assign ld2   = v1_q && free2;
  assign free1 = !v1_q || ld2;
  assign ld1   = valid_i && free1;
  assign pop_o = ld1;

  // nibbles used as they are, no bcd check
  always_comb begin
    for (int i = 0; i < civ_fd_pkg::NumData; i++) begin
      pair[i] = {4'd0, frame_i[i][7:4]} * 8'd10 + {4'd0, frame_i[i][3:0]};
    end
    tenth_prod = {8'd0, pair[0]} * civ_fd_pkg::RecipTen;
    term_d[0]  = W'(tenth_prod >> civ_fd_pkg::RecipShift);
    term_d[1]  = W'(pair[1]) * civ_fd_pkg::Weight1;
    term_d[2]  = W'(pair[2]) * civ_fd_pkg::Weight2;
    term_d[3]  = W'(pair[3]) * civ_fd_pkg::Weight3;
    term_d[4]  = W'(pair[4]) * civ_fd_pkg::Weight4;
  end

  assign band_d = civ_fd_pkg::classify_band(sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (free1) begin
        v1_q <= valid_i;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= 1'b1;
      end else if (ready_i) begin
        v3_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      term_q <= term_d;
    end
    if (ld2) begin
      sum_q <= term_q[0] + term_q[1] + term_q[2] + term_q[3] + term_q[4];
    end
    if (ld3) begin
      freq_q <= sum_q;
      band_q <= band_d;
      ant_q  <= civ_fd_pkg::pick_antenna(band_d);
    end
  end

  assign frequency_o = freq_q;
  assign band_o      = band_q;
  assign antenna_o   = ant_q;
  assign valid_o     = v3_q;

endmodule

`default_nettype wire

// ===== dv/civ_frequency_frame_decoder_core_test.sv =====
// self-checking testbench for civ_frequency_frame_decoder_core: directed frames, then random
// frames and noise checked against a frame decoder written here; depends on civ_fd_pkg
module civ_frequency_frame_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1200;
  localparam int unsigned TailItems   = 150;
  localparam int unsigned LongHold    = 250;
  localparam int unsigned NumDirected = 26;

  // amateur band edges, 10 Hz units, bands 1..11
  localparam int unsigned BandFloor [11] = '{
    181000, 350000, 535100, 700000, 1010000, 1400000,
    1806800, 2100000, 2489000, 2800000, 5000000
  };
  localparam int unsigned BandCeil [11] = '{
    200000, 380000, 536600, 720000, 1015000, 1435000,
    1816800, 2145000, 2499000, 2970000, 5200000
  };

  typedef struct packed {
    logic [civ_fd_pkg::FreqW-1:0] freq;
    logic [civ_fd_pkg::BandW-1:0] band;
    logic [civ_fd_pkg::AntW-1:0]  ant;
  } freq_result_t;

  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    freq_result_t want;
  } directed_row_t;

  localparam freq_result_t NoResult = '0;
  localparam freq_result_t MaxResult = '{31'd1666666666, 4'd0, civ_fd_pkg::AntNone};

  // max non-BCD frame, end byte at position 0, early end, frame with a bad eleventh byte
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{8'h00, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult}, '{8'h80, 1'b0, NoResult},
    '{8'h01, 1'b0, NoResult}, '{8'h7F, 1'b0, NoResult},
    '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult},
    '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult},
    '{civ_fd_pkg::EndByte, 1'b1, MaxResult},
    '{civ_fd_pkg::EndByte, 1'b0, NoResult},
    '{8'hFE, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{civ_fd_pkg::EndByte, 1'b0, NoResult},
    '{8'hFE, 1'b0, NoResult}, '{8'hFE, 1'b0, NoResult}, '{8'h94, 1'b0, NoResult},
    '{8'hE0, 1'b0, NoResult}, '{8'h03, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'hFE, 1'b0, NoResult}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic [7:0]                   rx_byte_i;
  logic                         rx_valid_i;
  logic                         rx_ready_o;
  logic [civ_fd_pkg::FreqW-1:0] frequency_o;
  logic [civ_fd_pkg::BandW-1:0] band_o;
  logic [civ_fd_pkg::AntW-1:0]  antenna_o;
  logic                         res_valid_o;
  logic                         res_ready_i;

  civ_frequency_frame_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .frequency_o (frequency_o),
    .band_o      (band_o),
    .antenna_o   (antenna_o),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i)
  );

  // decoder state mirrored here
  logic [3:0] frame_pos;
  logic [7:0] frame_data [civ_fd_pkg::NumData];

  freq_result_t freq_due [$];
  int unsigned  mismatches;
  int unsigned  words_sent;
  bit           idle_on;
  bit           hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("civ_frequency_frame_decoder_core: mismatch");
    $finish;
  end

  function automatic int unsigned digit_pair(input logic [7:0] b);
    return 32'(b[7:4]) * 10 + 32'(b[3:0]);
  endfunction

  // advance the frame state by one byte; returns 1 when a frame completes
  function automatic bit decode_frame_byte(input logic [7:0] b, output freq_result_t r);
    bit          at_last;
    int unsigned f;
    logic [3:0]  band;
    r = '0;
    at_last = frame_pos >= civ_fd_pkg::LastPos;
    if (frame_pos >= civ_fd_pkg::FirstData && frame_pos < civ_fd_pkg::LastPos) begin
      frame_data[3'(frame_pos - civ_fd_pkg::FirstData)] = b;
    end
    if (b != civ_fd_pkg::EndByte && !at_last) begin
      frame_pos = frame_pos + 4'd1;
      return 1'b0;
    end
    frame_pos = '0;
    if (!(b == civ_fd_pkg::EndByte && at_last)) begin
      return 1'b0;
    end
    f = digit_pair(frame_data[0]) / 10 + digit_pair(frame_data[1]) * 10
      + digit_pair(frame_data[2]) * 1000 + digit_pair(frame_data[3]) * 100000
      + digit_pair(frame_data[4]) * 10000000;
    band = '0;
    for (int i = 0; i < 11; i++) begin
      if (f >= BandFloor[i] && f <= BandCeil[i]) begin
        band = 4'(i + 1);
      end
    end
    r.freq = f[civ_fd_pkg::FreqW-1:0];
    r.band = band;
    if (band == 4'd0) begin
      r.ant = civ_fd_pkg::AntNone;
    end else if (band <= 4'd5) begin
      r.ant = civ_fd_pkg::AntLow;
    end else begin
      r.ant = civ_fd_pkg::AntHigh;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] any_but_end();
    int unsigned b;
    b = $urandom_range(0, 254);
    if (b >= civ_fd_pkg::EndByte) begin
      b++;
    end
    return 8'(b);
  endfunction

  function automatic logic [7:0] bcd_byte(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // offer one word and wait until it is taken
  task automatic offer_byte(input logic [7:0] b);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    rx_byte_i  <= b;
    rx_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    freq_result_t r;
    offer_byte(b);
    if (decode_frame_byte(b, r)) begin
      freq_due.push_back(r);
    end
  endtask

  task automatic send_random_frame();
    logic [7:0]  data [civ_fd_pkg::NumData];
    int unsigned mode, f, lo, hi, k;
    mode = $urandom_range(0, 19);
    if (mode < 10) begin
      // frequency aimed at a band, often right on or just past an edge
      k  = $urandom_range(0, 10);
      lo = BandFloor[k];
      hi = BandCeil[k];
      case ($urandom_range(0, 5))
        0: f = lo;
        1: f = hi;
        2: f = lo - 1;
        3: f = hi + 1;
        default: f = $urandom_range(lo, hi);
      endcase
      data[0] = {4'(f % 10), 4'($urandom_range(0, 9))};
      data[1] = bcd_byte((f / 10) % 100);
      data[2] = bcd_byte((f / 1000) % 100);
      data[3] = bcd_byte((f / 100000) % 100);
      data[4] = bcd_byte(f / 10000000);
    end else if (mode < 14) begin
      foreach (data[i]) data[i] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    end else if (mode < 19) begin
      foreach (data[i]) data[i] = any_but_end();
    end else begin
      foreach (data[i]) data[i] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < civ_fd_pkg::FirstData; i++) begin
      send_byte(any_but_end());
    end
    foreach (data[i]) send_byte(data[i]);
    send_byte(($urandom_range(0, 9) == 0) ? any_but_end() : civ_fd_pkg::EndByte);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (freq_due.size() != 0) @(negedge clk_i);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
        res_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        res_ready_i <= 1'b1;
      end else begin
        res_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    freq_result_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      if (freq_due.size() == 0) begin
        $display("%0t: expected no result, got frequency %0d band %0d antenna %0d",
                 $time, frequency_o, band_o, antenna_o);
        mismatches++;
      end else begin
        want = freq_due.pop_front();
        if (frequency_o !== want.freq) begin
          $display("%0t: frequency expected %0d, got %0d", $time, want.freq, frequency_o);
          mismatches++;
        end
        if (band_o !== want.band) begin
          $display("%0t: band expected %0d, got %0d", $time, want.band, band_o);
          mismatches++;
        end
        if (antenna_o !== want.ant) begin
          $display("%0t: antenna expected %0d, got %0d", $time, want.ant, antenna_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    freq_result_t r;
    bit           has;
    bit           drained;
    bit           tail_phase;
    int unsigned  pick, n;
    rst_ni     = 1'b0;
    rx_byte_i  = '0;
    rx_valid_i = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    mismatches = 0;
    words_sent = 0;
    frame_pos  = '0;
    drained    = 1'b0;
    tail_phase = 1'b0;
    foreach (frame_data[i]) frame_data[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      offer_byte(DirectedRows[i].rx);
      has = decode_frame_byte(DirectedRows[i].rx, r);
      if (DirectedRows[i].typed) begin
        freq_due.push_back(DirectedRows[i].want);
      end else if (has) begin
        freq_due.push_back(r);
      end
    end

    // receiver stalls for a long stretch while frames keep coming
    hold_req = 1'b1;
    while (words_sent < NumDirected + RandomItems) begin
      if (!tail_phase && words_sent > NumDirected + RandomItems - TailItems) begin
        tail_phase = 1'b1;
        idle_on    = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        idle_on = !idle_on;
      end
      if (!drained && words_sent > NumDirected + RandomItems / 2) begin
        drained = 1'b1;
        pause_until_drained();
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        send_random_frame();
      end else if (pick == 8) begin
        // line noise, then an end byte to resync
        n = $urandom_range(1, 12);
        repeat (n) begin
          send_byte(($urandom_range(0, 3) == 0) ? civ_fd_pkg::EndByte
                                                : 8'($urandom_range(0, 255)));
        end
        send_byte(civ_fd_pkg::EndByte);
      end else begin
        // frame cut short by an early end byte
        n = $urandom_range(1, 9);
        repeat (n) send_byte(any_but_end());
        send_byte(civ_fd_pkg::EndByte);
      end
    end

    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    while (freq_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("civ_frequency_frame_decoder_core: match");
    end else begin
      $display("civ_frequency_frame_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/civ_fd_pkg.sv
src/civ_fd_front.sv
src/civ_fd_queue.sv
src/civ_fd_back.sv
src/civ_frequency_frame_decoder_core.sv
dv/civ_frequency_frame_decoder_core_test.sv
